>>> hdl/rbb_pkg.sv
// ----------------------------------------------------------------------------
// rbb_pkg
// shared types and constants of the renko brick builder
// ----------------------------------------------------------------------------
package rbb_pkg;

  localparam int unsigned RbbMaxBricks = 64;
  localparam int unsigned PriceW       = 32;
  localparam int unsigned TimeW        = 48;
  localparam int unsigned BoxW         = 16;
  localparam logic [BoxW-1:0] BoxReset = 16'd100;

  localparam int unsigned InDataW  = 80;
  localparam int unsigned OutDataW = 112;
  localparam int unsigned OutUserW = 2;

  // request to the shared add/subtract unit
  typedef struct packed {
    logic [PriceW-1:0] a;
    logic [PriceW-1:0] b;
    logic              sub;
  } alu_req_t;

  // result: bit PriceW is carry on add, borrow on subtract
  typedef logic [PriceW:0] alu_res_t;

endpackage

>>> hdl/rbb_alu.sv
// ----------------------------------------------------------------------------
// rbb_alu
// shared 32-bit add/subtract unit with carry/borrow out
// ----------------------------------------------------------------------------
module rbb_alu (
  input  rbb_pkg::alu_req_t req_i,
  output rbb_pkg::alu_res_t res_o
);
  import rbb_pkg::*;

  always_comb begin
    if (req_i.sub) begin
      res_o = {1'b0, req_i.a} - {1'b0, req_i.b};
    end else begin
      res_o = {1'b0, req_i.a} + {1'b0, req_i.b};
    end
  end

endmodule

>>> hdl/rbb_seq.sv
// ----------------------------------------------------------------------------
// rbb_seq
// sequencer: direction test, brick count by repeated subtraction, emission
// ----------------------------------------------------------------------------
module rbb_seq #(
  parameter int unsigned MAX_BRICKS = rbb_pkg::RbbMaxBricks
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [rbb_pkg::BoxW-1:0]      box_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [rbb_pkg::PriceW-1:0]    in_price_i,
  input  logic [rbb_pkg::TimeW-1:0]     in_time_i,
  output rbb_pkg::alu_req_t             alu_req_o,
  input  rbb_pkg::alu_res_t             alu_res_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [rbb_pkg::PriceW-1:0]    out_open_o,
  output logic [rbb_pkg::PriceW-1:0]    out_close_o,
  output logic                          out_down_o,
  output logic [rbb_pkg::TimeW-1:0]     out_time_o,
  output logic                          out_last_o,
  output logic                          out_clip_o
);
  import rbb_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_BRICKS + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_DIFF, S_NEG, S_TEST, S_CLOSE, S_REM, S_LAST, S_OUT
  } state_e;

  state_e            state_q;
  logic              valid_q;
  logic [PriceW-1:0] ref_q, price_q, rem_q, open_q, close_q;
  logic [TimeW-1:0]  time_q;
  logic              down_q, last_q, clip_q, m_valid_q;
  logic [CntW-1:0]   cnt_q;
  logic [PriceW-1:0] box_ext;
  logic              at_max;

  assign box_ext = PriceW'(box_i);
  assign at_max  = (cnt_q == CntW'(MAX_BRICKS - 1));

  always_comb begin
    alu_req_o = '0;
    case (state_q)
      S_DIFF:  alu_req_o = '{a: price_q, b: ref_q,   sub: 1'b1};
      S_NEG:   alu_req_o = '{a: ref_q,   b: price_q, sub: 1'b1};
      S_TEST:  alu_req_o = '{a: rem_q,   b: box_ext, sub: 1'b1};
      S_CLOSE: alu_req_o = '{a: ref_q,   b: box_ext, sub: down_q};
      S_REM:   alu_req_o = '{a: rem_q,   b: box_ext, sub: 1'b1};
      S_LAST:  alu_req_o = '{a: rem_q,   b: box_ext, sub: 1'b1};
      default: alu_req_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      valid_q   <= 1'b0;
      ref_q     <= '0;
      price_q   <= '0;
      time_q    <= '0;
      rem_q     <= '0;
      open_q    <= '0;
      close_q   <= '0;
      down_q    <= 1'b0;
      last_q    <= 1'b0;
      clip_q    <= 1'b0;
      m_valid_q <= 1'b0;
      cnt_q     <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            price_q <= in_price_i;
            time_q  <= in_time_i;
            if (!valid_q) begin
              ref_q   <= in_price_i;
              valid_q <= 1'b1;
            end else if (box_i != '0) begin
              state_q <= S_DIFF;
            end
          end
        end
        S_DIFF: begin
          if (!alu_res_i[PriceW]) begin
            rem_q   <= alu_res_i[PriceW-1:0];
            down_q  <= 1'b0;
            state_q <= S_TEST;
          end else begin
            state_q <= S_NEG;
          end
        end
        S_NEG: begin
          rem_q   <= alu_res_i[PriceW-1:0];
          down_q  <= 1'b1;
          state_q <= S_TEST;
        end
        S_TEST: begin
          cnt_q <= '0;
          if (alu_res_i[PriceW]) begin
            state_q <= S_IDLE;
          end else begin
            state_q <= S_CLOSE;
          end
        end
        S_CLOSE: begin
          open_q  <= ref_q;
          close_q <= alu_res_i[PriceW-1:0];
          state_q <= S_REM;
        end
        S_REM: begin
          rem_q   <= alu_res_i[PriceW-1:0];
          state_q <= S_LAST;
        end
        S_LAST: begin
          last_q    <= alu_res_i[PriceW] || at_max;
          clip_q    <= at_max && !alu_res_i[PriceW];
          m_valid_q <= 1'b1;
          state_q   <= S_OUT;
        end
        S_OUT: begin
          if (out_ready_i) begin
            m_valid_q <= 1'b0;
            ref_q     <= close_q;
            if (last_q) begin
              state_q <= S_IDLE;
            end else begin
              cnt_q   <= cnt_q + CntW'(1);
              state_q <= S_CLOSE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = m_valid_q;
  assign out_open_o  = open_q;
  assign out_close_o = close_q;
  assign out_down_o  = down_q;
  assign out_time_o  = time_q;
  assign out_last_o  = last_q;
  assign out_clip_o  = clip_q;

`ifndef NO_ASSERTIONS
  a_ready_no_brick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o)
    else $error("input ready while a brick is pending");

  a_clip_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_clip_o) |-> out_last_o)
    else $error("clip flag on a brick that is not last");

  a_more_bricks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !out_last_o) |=> !in_ready_o)
    else $error("sequencer went idle in the middle of a run");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (cnt_q <= CntW'(MAX_BRICKS - 1)))
    else $error("brick count beyond limit");
`endif

endmodule

>>> hdl/renko_brick_builder.sv
// ----------------------------------------------------------------------------
// renko_brick_builder
// renko chart brick builder: price samples in, up/down bricks out
// ----------------------------------------------------------------------------
// channel  dir  request                     tdata / data
// s_axis   in   one price sample            price, timestamp
// m_axis   out  one brick                   open, close, time; tuser, tlast
// cfg      in   box_size write              box_size
//
// a sample is taken; the first one after reset or one with box size zero ends
// there. otherwise tests run S_DIFF, S_TEST on a rise and S_DIFF, S_NEG, S_TEST
// on a fall; each brick takes S_CLOSE, S_REM, S_LAST and S_OUT, which waits
// for m_axis_tready, all on the one shared 32-bit add/subtract unit.
// s_axis_tready is low while a sample is in work. no clearing pass after reset.
// ----------------------------------------------------------------------------
module renko_brick_builder #(
  parameter int unsigned MAX_BRICKS = rbb_pkg::RbbMaxBricks
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // price [31:0], timestamp [79:32]
  input  logic [rbb_pkg::InDataW-1:0]    s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // brick_open [31:0], brick_close [63:32], brick_time [111:64]
  output logic [rbb_pkg::OutDataW-1:0]   m_axis_tdata,
  // direction_down [0], count_clipped [1]
  output logic [rbb_pkg::OutUserW-1:0]   m_axis_tuser,
  output logic                           m_axis_tlast,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [rbb_pkg::BoxW-1:0]       cfg_data_i
);
  import rbb_pkg::*;

  logic [BoxW-1:0]   box_q;
  alu_req_t          alu_req;
  alu_res_t          alu_res;
  logic [PriceW-1:0] open_w, close_w;
  logic [TimeW-1:0]  time_w;
  logic              down_w, last_w, clip_w;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_q <= BoxReset;
    end else if (cfg_valid_i) begin
      box_q <= cfg_data_i;
    end
  end

  rbb_alu u_alu (
    .req_i (alu_req),
    .res_o (alu_res)
  );

  rbb_seq #(
    .MAX_BRICKS (MAX_BRICKS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .box_i       (box_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_price_i  (s_axis_tdata[PriceW-1:0]),
    .in_time_i   (s_axis_tdata[PriceW+TimeW-1:PriceW]),
    .alu_req_o   (alu_req),
    .alu_res_i   (alu_res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_open_o  (open_w),
    .out_close_o (close_w),
    .out_down_o  (down_w),
    .out_time_o  (time_w),
    .out_last_o  (last_w),
    .out_clip_o  (clip_w)
  );

  assign m_axis_tdata = {time_w, close_w, open_w};
  assign m_axis_tuser = {clip_w, down_w};
  assign m_axis_tlast = last_w;

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the renko brick builder
// ----------------------------------------------------------------------------
// a short table of directed samples and box writes, then random phases at
// several box sizes. every accepted sample runs through a local brick
// predictor; every brick out is compared field by field with the oldest
// pending one. the sender works in bursts, the sink stalls on its own
// pattern and once holds off long enough to stall the input.
// ----------------------------------------------------------------------------
module tb;
  import rbb_pkg::*;

  localparam int unsigned HoldOff      = 400;
  localparam int unsigned SettleCycles = 16;
  localparam int unsigned QuietLimit   = 4000;
  localparam int unsigned NumPhases    = 7;
  localparam int          NoCheck      = -1;
  localparam logic [TimeW-1:0]  TsMax  = '1;
  localparam logic [PriceW-1:0] PxMax  = '1;

  typedef enum logic {RowSample, RowBox} row_kind_e;
  typedef enum logic [2:0] {SinkOpen, SinkHalf, SinkMostly, SinkRarely, SinkPulse} sink_mode_e;

  typedef struct packed {
    row_kind_e         kind;
    logic [BoxW-1:0]   box;
    logic [PriceW-1:0] price;
    logic [TimeW-1:0]  ts;
    int                want_cnt;
    logic              want_clip;
  } stim_row_t;

  typedef struct packed {
    int   cnt;
    logic clip;
  } run_want_t;

  typedef struct packed {
    logic [PriceW-1:0] open;
    logic [PriceW-1:0] close;
    logic              down;
    logic [TimeW-1:0]  stamp;
    logic              last;
    logic              clip;
  } brick_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [OutUserW-1:0] m_axis_tuser;
  logic                m_axis_tlast;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [BoxW-1:0]     cfg_data = '0;

  // model of the block
  logic [PriceW-1:0] anchor_close = '0;
  logic              anchor_valid = 1'b0;
  logic [BoxW-1:0]   box_now = BoxReset;

  brick_t    brick_q [$];
  run_want_t run_want_q [$];

  int  errors = 0;
  int  quiet_cycles = 0;
  int  samples_seen = 0;
  int  bricks_seen = 0;
  int  clipped_runs = 0;
  int  box_writes = 0;
  int  burst_left = 0;
  bit  hold_req = 1'b0;

  stim_row_t dir_rows [25] = '{
    '{RowSample, 16'd0,     32'd1000,  48'd0,               0,  1'b0},
    '{RowSample, 16'd0,     32'd1099,  TsMax,               0,  1'b0},
    '{RowSample, 16'd0,     32'd1100,  48'hAAAA_AAAA_AAAA,  1,  1'b0},
    '{RowSample, 16'd0,     32'd1000,  48'h5555_5555_5555,  1,  1'b0},
    '{RowSample, 16'd0,     32'd0,     TsMax,               10, 1'b0},
    '{RowSample, 16'd0,     32'd99,    48'd1,               0,  1'b0},
    '{RowSample, 16'd0,     32'd0,     48'd2,               0,  1'b0},
    '{RowSample, 16'd0,     PxMax,     48'd0,               64, 1'b1},
    '{RowSample, 16'd0,     32'd0,     TsMax,               64, 1'b0},
    '{RowBox,    16'd1,     32'd0,     48'd0,               0,  1'b0},
    '{RowSample, 16'd0,     32'd64,    48'h0123_4567_89AB,  64, 1'b0},
    '{RowSample, 16'd0,     32'd65,    48'd3,               1,  1'b0},
    '{RowSample, 16'd0,     32'd0,     48'd4,               64, 1'b1},
    '{RowSample, 16'd0,     32'd0,     48'd5,               1,  1'b0},
    '{RowBox,    16'd65535, 32'd0,     48'd0,               0,  1'b0},
    '{RowSample, 16'd0,     32'd65534, 48'd6,               0,  1'b0},
    '{RowSample, 16'd0,     32'd65535, 48'd7,               1,  1'b0},
    '{RowSample, 16'd0,     PxMax,     TsMax,               64, 1'b1},
    '{RowSample, 16'd0,     32'd0,     48'd8,               64, 1'b1},
    '{RowBox,    16'd0,     32'd0,     48'd0,               0,  1'b0},
    '{RowSample, 16'd0,     PxMax,     48'd9,               0,  1'b0},
    '{RowSample, 16'd0,     32'd0,     48'd10,              0,  1'b0},
    '{RowBox,    16'd100,   32'd0,     48'd0,               0,  1'b0},
    '{RowSample, 16'd0,     32'd65735, 48'd11,              2,  1'b0},
    '{RowSample, 16'd0,     32'd65636, 48'd12,              0,  1'b0}
  };

  renko_brick_builder dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data)
  );

  always #1 clk = ~clk;

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic predict_bricks(input logic [PriceW-1:0] price, input logic [TimeW-1:0] stamp,
                                output int n, output logic clipped);
    longint unsigned a, b, p, diff, cnt, op;
    logic down;
    brick_t bk;
    n = 0;
    clipped = 1'b0;
    if (!anchor_valid) begin
      anchor_close = price;
      anchor_valid = 1'b1;
      return;
    end
    if (box_now == '0) return;
    a = anchor_close;
    b = box_now;
    p = price;
    if (p >= a + b) begin
      down = 1'b0;
      diff = p - a;
    end else if (a >= b && p <= a - b) begin
      down = 1'b1;
      diff = a - p;
    end else begin
      return;
    end
    cnt = diff / b;
    if (cnt > RbbMaxBricks) begin
      cnt = RbbMaxBricks;
      clipped = 1'b1;
    end
    for (longint unsigned i = 0; i < cnt; i++) begin
      op = down ? a - i * b : a + i * b;
      bk.open  = op[PriceW-1:0];
      bk.close = down ? 32'(op - b) : 32'(op + b);
      bk.down  = down;
      bk.stamp = stamp;
      bk.last  = (i + 1 == cnt);
      bk.clip  = (i + 1 == cnt) && clipped;
      brick_q = {brick_q, bk};
    end
    anchor_close = down ? 32'(a - cnt * b) : 32'(a + cnt * b);
    n = int'(cnt);
  endtask

  // checker and predictor
  always @(posedge clk) begin
    brick_t    bk;
    run_want_t w;
    int        n;
    logic      clipped;
    logic      moved;
    if (rst_n) begin
      moved = 1'b0;
      if (m_axis_tvalid && m_axis_tready) begin
        moved = 1'b1;
        bricks_seen++;
        if (brick_q.size() == 0) begin
          report_mismatch("brick with nothing pending", m_axis_tdata[31:0], 0);
        end else begin
          bk = brick_q.pop_front();
          if (m_axis_tdata[31:0] !== bk.open) report_mismatch("open", m_axis_tdata[31:0], bk.open);
          if (m_axis_tdata[63:32] !== bk.close)
            report_mismatch("close", m_axis_tdata[63:32], bk.close);
          if (m_axis_tdata[111:64] !== bk.stamp)
            report_mismatch("time", m_axis_tdata[111:64], bk.stamp);
          if (m_axis_tuser[0] !== bk.down) report_mismatch("direction", m_axis_tuser[0], bk.down);
          if (m_axis_tuser[1] !== bk.clip) report_mismatch("clipped", m_axis_tuser[1], bk.clip);
          if (m_axis_tlast !== bk.last) report_mismatch("last", m_axis_tlast, bk.last);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        moved = 1'b1;
        samples_seen++;
        predict_bricks(s_axis_tdata[31:0], s_axis_tdata[79:32], n, clipped);
        if (clipped) clipped_runs++;
        w = run_want_q.pop_front();
        if (w.cnt != NoCheck) begin
          if (n != w.cnt) report_mismatch("predicted brick count", n, w.cnt);
          if (clipped != w.clip) report_mismatch("predicted clip", clipped, w.clip);
        end
      end
      if (cfg_valid && cfg_ready) begin
        moved = 1'b1;
        box_now = cfg_data;
      end
      quiet_cycles <= moved ? 0 : quiet_cycles + 1;
    end
  end

  // sink: random stall pattern, one long hold-off on request
  initial begin : sink
    sink_mode_e mode;
    int left;
    mode = SinkOpen;
    left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HoldOff) @(posedge clk);
      end else begin
        if (left == 0) begin
          mode = sink_mode_e'($urandom_range(0, 4));
          left = $urandom_range(20, 80);
        end
        left--;
        case (mode)
          SinkOpen:   m_axis_tready <= 1'b1;
          SinkHalf:   m_axis_tready <= 1'($urandom_range(0, 1));
          SinkMostly: m_axis_tready <= ($urandom_range(0, 3) != 0);
          SinkRarely: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default:    m_axis_tready <= (left % 5 < 2);
        endcase
      end
    end
  end

  initial begin : watchdog
    @(posedge rst_n);
    while (quiet_cycles < QuietLimit) @(posedge clk);
    $display("timeout: no request for %0d cycles", QuietLimit);
    $display("== FAIL ==");
    $finish;
  end

  task automatic offer_sample(input logic [PriceW-1:0] price, input logic [TimeW-1:0] stamp,
                              input int want_cnt, input logic want_clip);
    int gap;
    run_want_t w;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    w.cnt  = want_cnt;
    w.clip = want_clip;
    run_want_q = {run_want_q, w};
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {stamp, price};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic drain_and_settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (brick_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_box(input logic [BoxW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    box_writes++;
  endtask

  function automatic logic [PriceW-1:0] pick_price(input logic [PriceW-1:0] last,
                                                   input logic [BoxW-1:0] box);
    longint p, b;
    int sel;
    b = (box == '0) ? 100 : box;
    sel = $urandom_range(0, 99);
    if (sel < 70) begin
      p = longint'(last) + (int'($urandom_range(0, 12)) - 6) * b
          + int'($urandom_range(0, int'(b) - 1));
    end else if (sel < 85) begin
      p = longint'(last) + int'($urandom_range(0, int'(b) - 1)) - b / 2;
    end else if (sel < 95) begin
      p = longint'(last) + ($urandom_range(0, 1) ? 1 : -1)
          * (64 + int'($urandom_range(0, 40))) * b;
    end else begin
      p = $urandom();
    end
    if (p < 0) p = 0;
    if (p > longint'(PxMax)) p = PxMax;
    return p[PriceW-1:0];
  endfunction

  initial begin : stimulus
    logic [BoxW-1:0]   phase_box [NumPhases];
    int                phase_items [NumPhases];
    logic [PriceW-1:0] last_px;
    logic [63:0]       rnd;
    phase_box   = '{16'd1, 16'd65535, 16'd0, 16'd0, 16'd0, 16'd7, 16'd100};
    phase_items = '{60, 50, 70, 60, 10, 60, 70};
    phase_box[2] = $urandom_range(2, 300);
    phase_box[3] = $urandom_range(1, 65535);
    last_px = '0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == RowBox) begin
        drain_and_settle();
        write_box(dir_rows[i].box);
      end else begin
        offer_sample(dir_rows[i].price, dir_rows[i].ts, dir_rows[i].want_cnt,
                     dir_rows[i].want_clip);
        last_px = dir_rows[i].price;
      end
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      drain_and_settle();
      write_box(phase_box[ph]);
      if (ph == 2) hold_req = 1'b1;
      for (int k = 0; k < phase_items[ph]; k++) begin
        last_px = pick_price(last_px, phase_box[ph]);
        rnd = {$urandom(), $urandom()};
        offer_sample(last_px, rnd[TimeW-1:0], NoCheck, 1'b0);
      end
    end

    drain_and_settle();
    $display("covered %0d samples and %0d bricks, %0d runs clipped at the brick limit",
             samples_seen, bricks_seen, clipped_runs);
    $display("box size written %0d times, including zero, one and full scale", box_writes);
    if (errors == 0 && brick_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d bricks still pending", errors, brick_q.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
